// ===== rtl/rts_pkg.sv =====
package rts_pkg;

    // Tile geometry.
    localparam int TILE_DIM       = 4;
    localparam int WORDS_PER_TILE = 8;
    localparam int PIXEL_BITS     = 32;

    // Alpha byte used when the input alpha is ignored.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Reset values of the configuration registers.
    localparam logic [10:0] LINE_WIDTH_RESET = 11'd1024;
    localparam logic        ALPHA_MODE_RESET = 1'b1;

    // Configuration register indexes.
    typedef enum logic
    {
        CFG_LINE_WIDTH = 1'b0,
        CFG_ALPHA_MODE = 1'b1
    } cfg_index_t;

    // One stored pixel: red, green, blue, alpha from the high byte down.
    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // One tile row of four pixels, and a whole 4x4 tile.
    typedef pixel_t [TILE_DIM-1:0] tile_row_t;

    typedef struct packed
    {
        tile_row_t [TILE_DIM-1:0] row;
    } tile_t;

    // Configuration as seen by the datapath.
    typedef struct packed
    {
        logic [10:0] line_width_px;
        logic        alpha_mode;
    } cfg_t;

    // Fill status of the tile queue.
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

    // Builds one output word from a tile row: alpha/red pairs or green/blue
    // pairs, with the first pixel in the top bits.
    function automatic logic [63:0] make_word(tile_row_t trow, logic green_blue);
        logic [63:0] word;
        pixel_t      p;
        word = '0;
        for (int k = 0; k < TILE_DIM; k++)
        begin
            p = trow[k];
            if (green_blue)
            begin
                word[63 - 16*k -: 16] = {p[23:16], p[15:8]};
            end
            else
            begin
                word[63 - 16*k -: 16] = {p[7:0], p[31:24]};
            end
        end
        return word;
    endfunction

endpackage

// ===== rtl/rts_front.sv =====
module rts_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rts_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            start_of_image,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic [7:0]      alpha,
    input  rts_pkg::q_stat_t q_stat,
    output logic            push,
    output rts_pkg::tile_t  tile
);
    import rts_pkg::*;

    localparam int GROUPS  = (MAX_WIDTH / TILE_DIM > 1) ? MAX_WIDTH / TILE_DIM : 1;
    localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int COL_W   = ($clog2(MAX_WIDTH) > GRP_W + 2) ? $clog2(MAX_WIDTH) : GRP_W + 2;
    localparam int XW      = (COL_W + 1 > 11) ? COL_W + 1 : 11;
    localparam int TOP_PX  = ((MAX_WIDTH / TILE_DIM) * TILE_DIM > TILE_DIM) ?
                             (MAX_WIDTH / TILE_DIM) * TILE_DIM : TILE_DIM;
    localparam int NBANKS  = (TILE_DIM - 1) * TILE_DIM;

    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       row_reg, row_next;
    logic             pend_valid_reg, pend_valid_next;
    tile_row_t        pend_r3_reg;
    pixel_t           r3_reg [TILE_DIM-1];
    pixel_t           rd_data [NBANKS];

    logic [XW-1:0]    width_raw, eff_w, col_inc;
    logic [COL_W-1:0] col_a, col_c;
    logic [1:0]       row_a, row_c;
    logic             accept, is_tile, rd_en;
    logic [GRP_W-1:0] grp;
    logic [7:0]       alpha_eff;
    pixel_t           px;

    // Effective width: low two bits dropped, clamped to the supported range.
    always_comb
    begin
        width_raw = XW'({cfg.line_width_px[10:2], 2'b00});
        if (width_raw < XW'(TILE_DIM))
        begin
            eff_w = XW'(TILE_DIM);
        end
        else if (width_raw > XW'(TOP_PX))
        begin
            eff_w = XW'(TOP_PX);
        end
        else
        begin
            eff_w = width_raw;
        end
    end

    // Position of this pixel and of the next one.
    always_comb
    begin
        col_a = start_of_image ? '0 : col_reg;
        row_a = start_of_image ? 2'd0 : row_reg;
        if (XW'(col_a) >= eff_w)
        begin
            col_c = '0;
            row_c = row_a + 2'd1;
        end
        else
        begin
            col_c = col_a;
            row_c = row_a;
        end
        col_inc = XW'(col_c) + XW'(1);
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = row_c + 2'd1;
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_c;
        end
    end

    assign alpha_eff = cfg.alpha_mode ? alpha : ALPHA_OPAQUE;
    assign px        = {red, green, blue, alpha_eff};
    assign grp       = col_c[2 +: GRP_W];
    assign is_tile   = (row_c == 2'(TILE_DIM - 1)) && (col_c[1:0] == 2'(TILE_DIM - 1));

    // A pending tile moves into the queue as soon as there is room.
    assign push     = pend_valid_reg && !q_stat.full;
    assign in_ready = !pend_valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept && is_tile;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (rd_en)
        begin
            pend_valid_next = 1'b1;
        end
        else if (push)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Position and pending-tile control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Band row 3 is kept in registers; the tile's last pixel joins it directly.
    always_ff @(posedge clk)
    begin
        if (accept && row_c == 2'(TILE_DIM - 1) && col_c[1:0] != 2'(TILE_DIM - 1))
        begin
            r3_reg[col_c[1:0]] <= px;
        end
        if (rd_en)
        begin
            pend_r3_reg <= {px, r3_reg[2], r3_reg[1], r3_reg[0]};
        end
    end

    // Line store for band rows 0 to 2: one bank per row and column mod 4,
    // so that a tile reads all twelve pixels together.
    for (genvar b = 0; b < NBANKS; b++)
    begin : g_bank
        localparam int BROW = b / TILE_DIM;
        localparam int BCOL = b % TILE_DIM;

        pixel_t mem [GROUPS];
        logic   wr_en;

        assign wr_en = accept && (row_c == 2'(BROW)) && (col_c[1:0] == 2'(BCOL));

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[grp] <= px;
            end
            if (rd_en)
            begin
                rd_data[b] <= mem[grp];
            end
        end
    end

    // Assemble the pending tile.
    always_comb
    begin
        for (int r = 0; r < TILE_DIM - 1; r++)
        begin
            for (int k = 0; k < TILE_DIM; k++)
            begin
                tile.row[r][k] = rd_data[r * TILE_DIM + k];
            end
        end
        tile.row[TILE_DIM-1] = pend_r3_reg;
    end

endmodule

// ===== rtl/rts_queue.sv =====
module rts_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rts_pkg::tile_t   push_tile,
    input  logic             pop,
    output rts_pkg::tile_t   head,
    output rts_pkg::q_stat_t stat
);
    import rts_pkg::*;

    tile_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Tile storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tile;
        end
    end

endmodule

// ===== rtl/rts_back.sv =====
module rts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rts_pkg::tile_t   head,
    input  rts_pkg::q_stat_t q_stat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      tile_word,
    output logic [2:0]       word_index,
    output logic             last_of_tile
);
    import rts_pkg::*;

    logic [2:0]  cnt_reg;
    logic        valid_reg, valid_next;
    logic [63:0] word_reg;
    logic [2:0]  index_reg;
    logic        last_reg;
    logic        load;
    logic        at_last;

    // A new word is loaded when the output register is free or being drained.
    assign load    = !q_stat.empty && (!valid_reg || out_ready);
    assign at_last = (cnt_reg == 3'(WORDS_PER_TILE - 1));
    assign pop     = load && at_last;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // Output word register: row from the low count bits, pair kind from the top bit.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= make_word(head.row[cnt_reg[1:0]], cnt_reg[2]);
            index_reg <= cnt_reg;
            last_reg  <= at_last;
        end
    end

    assign out_valid    = valid_reg;
    assign tile_word    = word_reg;
    assign word_index   = index_reg;
    assign last_of_tile = last_reg;

endmodule

// ===== rtl/rgba8_tile_swizzler.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   32+1   tdata: red, green, blue, alpha; tuser: start_of_image
// m_axis    out  64+3+1 tdata: tile_word; tuser: word_index; tlast: last_of_tile
// cfg       in   1+11   index 0 line_width_px, index 1 alpha_mode
//
// Pixels of band rows 0 to 2, and row-3 pixels that do not close a tile, are taken at
// one per cycle while the input is not stalled. A tile is sent as eight words at one
// word per cycle from the output register while the receiver is ready.
// A tile is read from the line store when its last pixel is accepted and waits in a
// two-entry queue; the input stalls only while that queue and the pending slot are full.
// Reset clears position, queue and output control; the line store is not cleared.
module rgba8_tile_swizzler #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic        s_axis_tuser,   // start_of_image [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // tile_word [63:0]
    output logic [2:0]  m_axis_tuser,   // word_index [2:0]
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata
);
    import rts_pkg::*;

    logic [10:0] line_width_reg;
    logic        alpha_mode_reg;
    cfg_t        cfg;
    q_stat_t     q_stat;
    tile_t       push_tile;
    tile_t       head;
    logic        push;
    logic        pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            alpha_mode_reg <= ALPHA_MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_LINE_WIDTH: line_width_reg <= cfg_wdata;
                CFG_ALPHA_MODE: alpha_mode_reg <= cfg_wdata[0];
                default:        line_width_reg <= line_width_reg;
            endcase
        end
    end

    assign cfg.line_width_px = line_width_reg;
    assign cfg.alpha_mode    = alpha_mode_reg;

    rts_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .start_of_image (s_axis_tuser),
        .red            (s_axis_tdata[7:0]),
        .green          (s_axis_tdata[15:8]),
        .blue           (s_axis_tdata[23:16]),
        .alpha          (s_axis_tdata[31:24]),
        .q_stat         (q_stat),
        .push           (push),
        .tile           (push_tile)
    );

    rts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tile (push_tile),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    rts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .tile_word    (m_axis_tdata),
        .word_index   (m_axis_tuser),
        .last_of_tile (m_axis_tlast)
    );

`ifndef SYNTH
    // The input only stalls while tiles wait for the back end.
    a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> !q_stat.empty)
        else $error("input stalled with an empty tile queue");

    // The last-word flag marks exactly the eighth word of a tile.
    a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'(WORDS_PER_TILE - 1))))
        else $error("tlast does not match word index");

    // An output word only appears when a tile was queued.
    a_word_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!q_stat.empty))
        else $error("output word without a queued tile");

    // The queue is popped only on a tile's last word, and never while empty.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("tile queue popped while empty");
`endif

endmodule

// ===== tb/tb_rgba8_tile_swizzler.sv =====
module tb_rgba8_tile_swizzler;

    timeunit 1ns;
    timeprecision 1ps;

    import rts_pkg::*;

    localparam int MAX_PX        = 1024;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 300;

    // One output word as the tile predictor expects it.
    typedef struct
    {
        logic [63:0] tile_word;
        logic [2:0]  word_index;
        logic        last_of_tile;
    } tile_word_t;

    // Tracks the raster position and a copy of the line store, builds the eight
    // words of each completed tile and checks them against the block's output.
    class tile_scoreboard;
        logic [10:0] width_reg;
        logic        alpha_mode;
        int          column;
        int          band;
        pixel_t      line_copy [TILE_DIM][MAX_PX];
        tile_word_t  expected_words [$];
        int          fail_count;

        function new();
            width_reg  = LINE_WIDTH_RESET;
            alpha_mode = ALPHA_MODE_RESET;
            column     = 0;
            band       = 0;
            fail_count = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [10:0] value);
            if (idx == CFG_LINE_WIDTH)
            begin
                width_reg = value;
            end
            else
            begin
                alpha_mode = value[0];
            end
        endfunction

        function int pending_words();
            return expected_words.size();
        endfunction

        // Stores one accepted pixel and queues a tile when the pixel closes one.
        function void note_pixel(logic sop, logic [31:0] data);
            int          w;
            int          base;
            logic [7:0]  alpha;
            pixel_t      p;
            logic [63:0] word;
            tile_word_t  e;
            // The low two width bits are dropped and the width is clamped.
            w = int'(width_reg) & ~3;
            if (w < TILE_DIM)
            begin
                w = TILE_DIM;
            end
            if (w > (MAX_PX & ~3))
            begin
                w = MAX_PX & ~3;
            end
            alpha = alpha_mode ? data[31:24] : ALPHA_OPAQUE;
            if (sop)
            begin
                column = 0;
                band   = 0;
            end
            // A width lowered below the current column ends the line at once.
            if (column >= w)
            begin
                column = 0;
                band   = (band + 1) % TILE_DIM;
            end
            line_copy[band][column] = {data[7:0], data[15:8], data[23:16], alpha};
            if (band == TILE_DIM - 1 && column % TILE_DIM == TILE_DIM - 1)
            begin
                base = column - (TILE_DIM - 1);
                for (int wi = 0; wi < WORDS_PER_TILE; wi++)
                begin
                    word = '0;
                    for (int k = 0; k < TILE_DIM; k++)
                    begin
                        p = line_copy[wi % TILE_DIM][base + k];
                        if (wi < TILE_DIM)
                        begin
                            word = {word[47:0], p[7:0], p[31:24]};
                        end
                        else
                        begin
                            word = {word[47:0], p[23:16], p[15:8]};
                        end
                    end
                    e.tile_word    = word;
                    e.word_index   = 3'(wi);
                    e.last_of_tile = (wi == WORDS_PER_TILE - 1);
                    expected_words.push_back(e);
                end
            end
            column = column + 1;
            if (column >= w)
            begin
                column = 0;
                band   = (band + 1) % TILE_DIM;
            end
        endfunction

        // Compares one output word with the oldest expected word.
        function void check_word(logic [63:0] data, logic [2:0] index, logic last);
            tile_word_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: tile_word %h, word_index %0d", data, index);
                fail_count++;
                return;
            end
            e = expected_words.pop_front();
            if (data !== e.tile_word)
            begin
                $error("tile_word: expected %h, actual %h", e.tile_word, data);
                fail_count++;
            end
            if (index !== e.word_index)
            begin
                $error("word_index: expected %0d, actual %0d", e.word_index, index);
                fail_count++;
            end
            if (last !== e.last_of_tile)
            begin
                $error("last_of_tile: expected %0b, actual %0b", e.last_of_tile, last);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_addr = CFG_LINE_WIDTH;
    logic [10:0] cfg_wdata = '0;

    int phase_num = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    tile_scoreboard board = new();

    rgba8_tile_swizzler #(
        .MAX_WIDTH(MAX_PX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
        .s_axis_tuser (s_axis_tuser),   // start_of_image [0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // tile_word [63:0]
        .m_axis_tuser (m_axis_tuser),   // word_index [2:0]
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output word monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Receiver: random stalls, plus one long hold-off so the tile queue fills.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (phase_num == HOLD_PHASE && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Waits until all tiles are out, then writes both registers.
    task automatic set_phase(int num, logic [10:0] width_val, logic alpha_val,
                             int send_pct, int recv_pct);
        while (board.pending_words() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        phase_num     <= num;
        recv_idle_pct <= recv_pct;
        send_idle_pct = send_pct;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_LINE_WIDTH;
        cfg_wdata <= width_val;
        @(posedge clk);
        cfg_addr  <= CFG_ALPHA_MODE;
        cfg_wdata <= {10'd0, alpha_val};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.write_reg(CFG_LINE_WIDTH, width_val);
        board.write_reg(CFG_ALPHA_MODE, {10'd0, alpha_val});
    endtask

    // Offers one pixel word after a random gap and waits for it to be taken.
    task automatic send_pixel(logic sop, logic [31:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= sop;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        board.note_pixel(sop, data);
    endtask

    // Random pixels in raster order; a start flag now and then.
    task automatic run_pixels(int count, bit first_sop, int sop_pct);
        logic sop;
        for (int i = 0; i < count; i++)
        begin
            sop = (i == 0 && first_sop) || ($urandom_range(0, 99) < sop_pct);
            send_pixel(sop, $urandom);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        logic [7:0] patterns [8];
        patterns = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: width below four, bit patterns on every byte, a restart
        // in the middle of a band, then one full tile.
        set_phase(0, 11'd3, 1'b1, 10, 57);
        for (int i = 0; i < 22; i++)
        begin
            send_pixel(i == 0 || i == 6,
                       {patterns[(i + 3) % 8], patterns[(i + 2) % 8],
                        patterns[(i + 1) % 8], patterns[i % 8]});
        end
        s_axis_tvalid <= 1'b0;

        // Forced alpha, then a short run at an out-of-range width value.
        set_phase(1, 11'd8, 1'b0, 10, 57);
        run_pixels(40, 1'b1, 2);
        set_phase(2, 11'd2047, 1'b1, 10, 57);
        run_pixels(16, 1'b1, 0);

        // Stop mid-line, then lower the width so the line ends at once.
        set_phase(3, 11'd16, 1'b1, 57, 10);
        run_pixels(36, 1'b1, 0);
        set_phase(4, 11'd6, 1'b0, 57, 10);
        run_pixels(28, 1'b0, 2);

        // No idling; the receiver holds off for a long stretch in this phase.
        set_phase(HOLD_PHASE, 11'd4, 1'b1, 0, 0);
        run_pixels(64, 1'b1, 1);
        set_phase(6, 11'd13, 1'b0, 0, 0);
        run_pixels(40, 1'b1, 2);
        set_phase(7, 11'd0, 1'b1, 0, 0);
        run_pixels(24, 1'b1, 2);

        while (board.pending_words() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Run time limit.
    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
